@@ rtl/fsel_pkg.sv @@
// Package for the fault supervisor with error log.
// Holds shared constants, codes and the queue entry type; no dependencies.
package fsel_pkg;

    localparam int LOG_DEPTH = 16;
    localparam int PTR_W     = $clog2(LOG_DEPTH);
    localparam int FILL_W    = $clog2(LOG_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_LOG   = 2'd0,
        OP_DUMP  = 2'd1,
        OP_RESET = 2'd2,
        OP_CHECK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_WARNING  = 2'd1,
        MODE_ERROR    = 2'd2,
        MODE_RECOVERY = 2'd3
    } mode_t;

    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_ENTRY  = 3'd1;
    localparam logic [2:0] KIND_TERM   = 3'd2;
    localparam logic [2:0] KIND_ACK    = 3'd3;
    localparam logic [2:0] KIND_NACK   = 3'd4;

    localparam logic [7:0] RESET_KEY     = 8'hAA;
    localparam logic [7:0] CODE_RST_ACK  = 8'hBB;
    localparam logic [7:0] CODE_RCV_ACK  = 8'hAA;
    localparam logic [7:0] CODE_BAD_KEY  = 8'h00;
    localparam logic [7:0] CODE_NOT_ERR  = 8'h01;
    localparam logic [7:0] CODE_OVERVOLT = 8'hCC;
    localparam logic [7:0] CODE_FAIL     = 8'hEE;
    localparam logic [15:0] TIMEOUT_DET  = 16'hFFFF;

    localparam logic [1:0] REG_BUS_OV  = 2'd0;
    localparam logic [1:0] REG_MOD_OC  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_STABLE  = 2'd3;

    localparam logic [1:0] SEV_WARN = 2'd1;
    localparam logic [1:0] SEV_CRIT = 2'd2;

    // Classified command held between front and back
    typedef struct packed {
        op_t         op;
        logic [31:0] now_ms;
        logic [2:0]  source;
        logic [1:0]  severity;
        logic [15:0] detail;
        logic        key_ok;
        logic [15:0] bus_mv;
        logic [47:0] currents;
        logic [2:0]  current_valid;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DUMP = 2'd1,
        ST_TERM = 2'd2
    } back_state_t;

endpackage

@@ rtl/fsel_front.sv @@
// Front end: accepts input transfers, checks the reset key and queues commands.
// Depends on fsel_pkg.
module fsel_front
    import fsel_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [31:0] s_now_ms,
    input  logic [2:0]  s_source,
    input  logic [1:0]  s_severity,
    input  logic [15:0] s_detail,
    input  logic        s_key_present,
    input  logic [7:0]  s_reset_key,
    input  logic [15:0] s_bus_mv,
    input  logic [15:0] s_drive_current_ma,
    input  logic [15:0] s_extruder_current_ma,
    input  logic [15:0] s_scrub_current_ma,
    input  logic [2:0]  s_current_valid,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);

    // Two-entry queue
    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       cmd_in;
    logic       push, pop;

    always_comb begin
        cmd_in.op            = op_t'(s_op);
        cmd_in.now_ms        = s_now_ms;
        cmd_in.source        = s_source;
        cmd_in.severity      = s_severity;
        cmd_in.detail        = s_detail;
        cmd_in.key_ok        = s_key_present && (s_reset_key == RESET_KEY);
        cmd_in.bus_mv        = s_bus_mv;
        cmd_in.currents      = {s_scrub_current_ma, s_extruder_current_ma,
                                s_drive_current_ma};
        cmd_in.current_valid = s_current_valid;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/fsel_back.sv @@
// Back end: mode control, ring log, lockouts, recovery checks and dump walk.
// Depends on fsel_pkg.
module fsel_back
    import fsel_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_reply_code,
    output logic [5:0]  m_entry_number,
    output logic [2:0]  m_entry_source,
    output logic [1:0]  m_entry_severity,
    output logic [15:0] m_entry_detail,
    output logic [23:0] m_entry_time,
    output logic [1:0]  m_mode,
    output logic        m_power_allowed,
    output logic [3:0]  m_lockout_mask,
    output logic [5:0]  m_log_count,
    output logic        m_last
);

    // Configuration registers
    logic [15:0] bus_ov_reg, mod_oc_reg;
    logic [31:0] timeout_reg;
    logic [7:0]  stable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_ov_reg  <= 16'd30000;
            mod_oc_reg  <= 16'd10000;
            timeout_reg <= 32'd5000;
            stable_reg  <= 8'd10;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BUS_OV:  bus_ov_reg  <= cfg_data[15:0];
                REG_MOD_OC:  mod_oc_reg  <= cfg_data[15:0];
                REG_TIMEOUT: timeout_reg <= cfg_data;
                REG_STABLE:  stable_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Supervisor state
    mode_t              mode_reg, mode_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [2:0]         lock_reg, lock_next;
    logic               all_reg, all_next;
    logic [7:0]         clean_reg, clean_next;
    logic [31:0]        rstart_reg, rstart_next;
    back_state_t        st_reg, st_next;
    logic [FILL_W-1:0]  idx_reg, idx_next;

    // Log memory: src, sev, detail, stamp
    logic [44:0]        log_mem [LOG_DEPTH];
    logic [44:0]        rd_data_reg;
    logic               log_we;
    logic [44:0]        log_wdata;
    logic [PTR_W-1:0]   rd_addr;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  code_reg, code_next;
    logic [5:0]  num_reg, num_next;
    logic        entry_reg, entry_next;
    logic        last_reg, last_next;

    logic        out_free;
    logic [31:0] elapsed;
    logic        oc_hit;
    logic [1:0]  oc_idx;
    logic [15:0] oc_val;
    logic [2:0]  ev_src;
    logic [1:0]  ev_sev;
    logic [15:0] ev_det;
    logic        do_log;
    logic [7:0]  clean_inc;
    logic [FILL_W:0] start_sum;
    logic        rd_pending_reg;

    assign out_free = !out_valid_reg || m_ready;
    assign elapsed  = q_cmd.now_ms - rstart_reg;
    assign clean_inc = clean_reg + 8'd1;

    // First valid module at or over the current limit, in module order
    always_comb begin
        oc_hit = 1'b0;
        oc_idx = 2'd0;
        oc_val = 16'd0;
        for (int i = 2; i >= 0; i--) begin
            if (q_cmd.current_valid[i] && q_cmd.currents[16*i +: 16] >= mod_oc_reg) begin
                oc_hit = 1'b1;
                oc_idx = 2'(i);
                oc_val = q_cmd.currents[16*i +: 16];
            end
        end
    end

    // Ring read address for the next dump frame
    always_comb begin
        if (fill_reg < FILL_W'(LOG_DEPTH)) begin
            start_sum = {1'b0, idx_reg};
        end else begin
            start_sum = (FILL_W+1)'(head_reg) + (FILL_W+1)'(idx_reg);
        end
        if (start_sum >= (FILL_W+1)'(LOG_DEPTH)) begin
            start_sum = start_sum - (FILL_W+1)'(LOG_DEPTH);
        end
        rd_addr = start_sum[PTR_W-1:0];
    end

    // Command execution
    always_comb begin
        mode_next      = mode_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        lock_next      = lock_reg;
        all_next       = all_reg;
        clean_next     = clean_reg;
        rstart_next    = rstart_reg;
        st_next        = st_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        kind_next      = kind_reg;
        code_next      = code_reg;
        num_next       = num_reg;
        entry_next     = entry_reg;
        last_next      = last_reg;
        q_ready        = 1'b0;
        do_log         = 1'b0;
        ev_src         = q_cmd.source;
        ev_sev         = q_cmd.severity;
        ev_det         = q_cmd.detail;

        unique case (st_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_ready        = 1'b1;
                    out_valid_next = 1'b1;
                    kind_next      = KIND_STATUS;
                    code_next      = 8'd0;
                    num_next       = 6'd0;
                    entry_next     = 1'b0;
                    last_next      = 1'b1;
                    unique case (q_cmd.op)
                        OP_LOG: do_log = 1'b1;
                        OP_DUMP: begin
                            idx_next = '0;
                            if (fill_reg == '0) begin
                                kind_next = KIND_TERM;
                            end else begin
                                out_valid_next = 1'b0;
                                st_next        = ST_DUMP;
                            end
                        end
                        OP_RESET: begin
                            kind_next = KIND_NACK;
                            if (!q_cmd.key_ok) begin
                                code_next = CODE_BAD_KEY;
                            end else if (mode_reg != MODE_ERROR) begin
                                code_next = CODE_NOT_ERR;
                            end else begin
                                kind_next   = KIND_ACK;
                                code_next   = CODE_RST_ACK;
                                head_next   = '0;
                                fill_next   = '0;
                                mode_next   = MODE_RECOVERY;
                                clean_next  = 8'd0;
                                rstart_next = q_cmd.now_ms;
                            end
                        end
                        OP_CHECK: begin
                            if (mode_reg != MODE_RECOVERY) begin
                                kind_next = KIND_STATUS;
                            end else if (elapsed >= timeout_reg) begin
                                mode_next = MODE_ERROR;
                                do_log    = 1'b1;
                                ev_src    = 3'd0;
                                ev_sev    = SEV_CRIT;
                                ev_det    = TIMEOUT_DET;
                                kind_next = KIND_NACK;
                                code_next = CODE_FAIL;
                            end else if (q_cmd.bus_mv >= bus_ov_reg) begin
                                clean_next = 8'd0;
                                do_log     = 1'b1;
                                ev_src     = 3'd5;
                                ev_sev     = SEV_CRIT;
                                ev_det     = q_cmd.bus_mv;
                                kind_next  = KIND_NACK;
                                code_next  = CODE_OVERVOLT;
                            end else if (oc_hit) begin
                                clean_next = 8'd0;
                                do_log     = 1'b1;
                                ev_src     = 3'(oc_idx) + 3'd1;
                                ev_sev     = SEV_CRIT;
                                ev_det     = oc_val;
                                kind_next  = KIND_NACK;
                                code_next  = CODE_FAIL;
                            end else if (clean_inc >= stable_reg) begin
                                lock_next  = 3'd0;
                                all_next   = 1'b0;
                                clean_next = 8'd0;
                                mode_next  = MODE_NORMAL;
                                kind_next  = KIND_ACK;
                                code_next  = CODE_RCV_ACK;
                            end else begin
                                clean_next = clean_inc;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DUMP: begin
                // read data for idx_reg arrives the cycle after issue
                if (rd_pending_reg && out_free) begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ENTRY;
                    code_next      = 8'd0;
                    num_next       = 6'(idx_reg);
                    entry_next     = 1'b1;
                    last_next      = 1'b0;
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == fill_reg) st_next = ST_TERM;
                end
            end
            ST_TERM: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_TERM;
                    num_next       = 6'd0;
                    entry_next     = 1'b0;
                    last_next      = 1'b1;
                    st_next        = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase

        // Apply a logged event: ring write and mode/lockout effect
        if (do_log) begin
            head_next = (head_reg == PTR_W'(LOG_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            if (fill_reg < FILL_W'(LOG_DEPTH)) fill_next = fill_reg + 1'b1;
            if (ev_sev == SEV_CRIT) begin
                mode_next = MODE_ERROR;
                if (ev_src >= 3'd1 && ev_src <= 3'd3) begin
                    lock_next = lock_reg | (3'd1 << (ev_src - 3'd1));
                end else begin
                    all_next = 1'b1;
                end
            end else if (ev_sev == SEV_WARN && mode_reg == MODE_NORMAL) begin
                mode_next = MODE_WARNING;
            end
        end
    end

    assign log_we    = do_log;
    assign log_wdata = {ev_src, ev_sev, ev_det, q_cmd.now_ms[23:0]};

    // Log memory with registered read
    always_ff @(posedge aclk) begin
        if (log_we) log_mem[head_reg] <= log_wdata;
        rd_data_reg <= log_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_NORMAL;
            head_reg       <= '0;
            fill_reg       <= '0;
            lock_reg       <= 3'd0;
            all_reg        <= 1'b0;
            clean_reg      <= 8'd0;
            rstart_reg     <= 32'd0;
            st_reg         <= ST_IDLE;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            rd_pending_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            lock_reg      <= lock_next;
            all_reg       <= all_next;
            clean_reg     <= clean_next;
            rstart_reg    <= rstart_next;
            st_reg        <= st_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            // a read is valid once the dump index is held unchanged while in ST_DUMP
            rd_pending_reg <= (st_next == ST_DUMP) && (st_reg == ST_DUMP)
                              && (idx_next == idx_reg);
        end
    end

    // Result payload registers
    logic [44:0] ent_reg;
    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        code_reg  <= code_next;
        num_reg   <= num_next;
        entry_reg <= entry_next;
        last_reg  <= last_next;
        if (st_reg == ST_DUMP && rd_pending_reg && out_free) ent_reg <= rd_data_reg;
    end

    // Status fields reflect the state after the step
    assign m_valid          = out_valid_reg;
    assign m_kind           = kind_reg;
    assign m_reply_code     = code_reg;
    assign m_entry_number   = entry_reg ? num_reg : 6'd0;
    assign m_entry_source   = entry_reg ? ent_reg[44:42] : 3'd0;
    assign m_entry_severity = entry_reg ? ent_reg[41:40] : 2'd0;
    assign m_entry_detail   = entry_reg ? ent_reg[39:24] : 16'd0;
    assign m_entry_time     = entry_reg ? ent_reg[23:0] : 24'd0;
    assign m_mode           = mode_reg;
    assign m_power_allowed  = (mode_reg == MODE_NORMAL) || (mode_reg == MODE_WARNING);
    assign m_lockout_mask   = ((mode_reg == MODE_ERROR) || (mode_reg == MODE_RECOVERY))
                              ? {all_reg, lock_reg} : 4'd0;
    assign m_log_count      = 6'(fill_reg);
    assign m_last           = last_reg;

endmodule

@@ rtl/fault_supervisor_with_error_log.sv @@
// Top level of the fault supervisor with error log.
// Depends on fsel_pkg, fsel_front and fsel_back.
//
// Commands are queued by the front end (two deep) and executed by the back end one at a
// time. Log, reset and check commands give one result each; a dump gives one entry frame
// per entry held in the log, each from a registered read of the log memory, then a
// terminator. Status fields show the state after each step.
// No clearing pass is needed after reset.
module fault_supervisor_with_error_log
    import fsel_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [31:0] s_now_ms,
    input  logic [2:0]  s_source,
    input  logic [1:0]  s_severity,
    input  logic [15:0] s_detail,
    input  logic        s_key_present,
    input  logic [7:0]  s_reset_key,
    input  logic [15:0] s_bus_mv,
    input  logic [15:0] s_drive_current_ma,
    input  logic [15:0] s_extruder_current_ma,
    input  logic [15:0] s_scrub_current_ma,
    input  logic [2:0]  s_current_valid,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_reply_code,
    output logic [5:0]  m_entry_number,
    output logic [2:0]  m_entry_source,
    output logic [1:0]  m_entry_severity,
    output logic [15:0] m_entry_detail,
    output logic [23:0] m_entry_time,
    output logic [1:0]  m_mode,
    output logic        m_power_allowed,
    output logic [3:0]  m_lockout_mask,
    output logic [5:0]  m_log_count,
    output logic        m_last
);

    logic q_valid, q_ready;
    cmd_t q_cmd;

    fsel_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_op, .s_now_ms, .s_source,
        .s_severity, .s_detail, .s_key_present, .s_reset_key, .s_bus_mv,
        .s_drive_current_ma, .s_extruder_current_ma, .s_scrub_current_ma,
        .s_current_valid, .q_valid, .q_ready, .q_cmd
    );

    fsel_back u_back (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_ready,
        .q_cmd, .m_valid, .m_ready, .m_kind, .m_reply_code, .m_entry_number,
        .m_entry_source, .m_entry_severity, .m_entry_detail, .m_entry_time,
        .m_mode, .m_power_allowed, .m_lockout_mask, .m_log_count, .m_last
    );

endmodule

@@ rtl/fsel_checker.sv @@
// Port-level checker for the fault supervisor, bound to the top level.
// Depends on fsel_pkg.
module fsel_checker
    import fsel_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_kind,
    input logic [1:0] m_mode,
    input logic       m_power_allowed,
    input logic [3:0] m_lockout_mask,
    input logic       m_last
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind))
        else $error("result dropped while stalled");

    a_power: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_power_allowed == (m_mode == MODE_NORMAL || m_mode == MODE_WARNING))
        else $error("power flag disagrees with mode");

    a_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_power_allowed |-> m_lockout_mask == 4'd0)
        else $error("lockout shown while power allowed");

    a_entry_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ENTRY |-> !m_last)
        else $error("entry frame marked last");

endmodule

bind fault_supervisor_with_error_log fsel_checker u_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_kind, .m_mode, .m_power_allowed,
    .m_lockout_mask, .m_last
);

@@ verif/fault_supervisor_with_error_log_test.sv @@
// Self-checking testbench for the fault supervisor with error log.
// Depends on fsel_pkg and fault_supervisor_with_error_log; needs no files.
`timescale 1ns / 100ps

module fault_supervisor_with_error_log_test;
    import fsel_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        op_t         op;
        logic [31:0] now_ms;
        logic [2:0]  source;
        logic [1:0]  severity;
        logic [15:0] detail;
        logic        key_present;
        logic [7:0]  reset_key;
        logic [15:0] bus_mv;
        logic [15:0] drive_ma;
        logic [15:0] extruder_ma;
        logic [15:0] scrub_ma;
        logic [2:0]  current_valid;
    } command_t;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  code;
        logic [5:0]  num;
        logic [2:0]  src;
        logic [1:0]  sev;
        logic [15:0] det;
        logic [23:0] stamp;
        logic [1:0]  mode;
        logic        power;
        logic [3:0]  lock;
        logic [5:0]  count;
        logic        last;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = '0;
    logic [31:0] s_now_ms = '0;
    logic [2:0]  s_source = '0;
    logic [1:0]  s_severity = '0;
    logic [15:0] s_detail = '0;
    logic        s_key_present = 1'b0;
    logic [7:0]  s_reset_key = '0;
    logic [15:0] s_bus_mv = '0;
    logic [15:0] s_drive_current_ma = '0;
    logic [15:0] s_extruder_current_ma = '0;
    logic [15:0] s_scrub_current_ma = '0;
    logic [2:0]  s_current_valid = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [7:0]  m_reply_code;
    logic [5:0]  m_entry_number;
    logic [2:0]  m_entry_source;
    logic [1:0]  m_entry_severity;
    logic [15:0] m_entry_detail;
    logic [23:0] m_entry_time;
    logic [1:0]  m_mode;
    logic        m_power_allowed;
    logic [3:0]  m_lockout_mask;
    logic [5:0]  m_log_count;
    logic        m_last;

    fault_supervisor_with_error_log u_top (.*);

    always #5 aclk = ~aclk;

    // Supervisor shadow: configuration and state
    logic [15:0] sh_bus_ov, sh_mod_oc;
    logic [31:0] sh_timeout;
    logic [7:0]  sh_stable;
    mode_t       sh_mode;
    logic [2:0]  log_src [LOG_DEPTH];
    logic [1:0]  log_sev [LOG_DEPTH];
    logic [15:0] log_det [LOG_DEPTH];
    logic [23:0] log_stamp [LOG_DEPTH];
    int          log_head, log_fill;
    logic [2:0]  sh_mod_lock;
    logic        sh_all_lock;
    logic [7:0]  sh_clean;
    logic [31:0] sh_rcv_start;

    command_t    pending_cmds[$];
    reply_t      expected_replies[$];
    command_t    on_bus;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_request = 0;
    int          hold_left = 0;
    bit          failed = 0;
    int          cycles = 0;
    logic [31:0] clock_ms = 0;

    function automatic void push_reply(logic [2:0] kind, logic [7:0] code, int idx,
                                       logic [5:0] num, bit is_entry);
        reply_t r;
        r = '{default: '0};
        r.kind = kind;
        r.code = code;
        if (is_entry) begin
            r.num   = num;
            r.src   = log_src[idx];
            r.sev   = log_sev[idx];
            r.det   = log_det[idx];
            r.stamp = log_stamp[idx];
        end
        r.mode  = sh_mode;
        r.power = (sh_mode == MODE_NORMAL || sh_mode == MODE_WARNING);
        if (sh_mode == MODE_ERROR || sh_mode == MODE_RECOVERY)
            r.lock = {sh_all_lock, sh_mod_lock};
        r.count = 6'(log_fill);
        expected_replies.push_back(r);
    endfunction

    function automatic void store_event(logic [2:0] src, logic [1:0] sev, logic [15:0] det,
                                        logic [31:0] now);
        log_src[log_head]   = src;
        log_sev[log_head]   = sev;
        log_det[log_head]   = det;
        log_stamp[log_head] = now[23:0];
        log_head = (log_head + 1) % LOG_DEPTH;
        if (log_fill < LOG_DEPTH) log_fill++;
        if (sev == SEV_CRIT) begin
            sh_mode = MODE_ERROR;
            if (src >= 1 && src <= 3) sh_mod_lock[src - 1] = 1'b1;
            else sh_all_lock = 1'b1;
        end else if (sev == SEV_WARN && sh_mode == MODE_NORMAL) begin
            sh_mode = MODE_WARNING;
        end
    endfunction

    // Works out the replies that one accepted command causes
    function automatic void predict_replies(command_t c);
        int start;
        logic [15:0] cur [3];
        bit tripped;
        tripped = 0;
        cur[0] = c.drive_ma;
        cur[1] = c.extruder_ma;
        cur[2] = c.scrub_ma;
        case (c.op)
            OP_LOG: begin
                store_event(c.source, c.severity, c.detail, c.now_ms);
                push_reply(KIND_STATUS, 8'h00, 0, 0, 0);
            end
            OP_DUMP: begin
                start = (log_fill < LOG_DEPTH) ? 0 : log_head;
                for (int i = 0; i < log_fill; i++)
                    push_reply(KIND_ENTRY, 8'h00, (start + i) % LOG_DEPTH, 6'(i), 1);
                push_reply(KIND_TERM, 8'h00, 0, 0, 0);
            end
            OP_RESET: begin
                if (!c.key_present || c.reset_key != RESET_KEY) begin
                    push_reply(KIND_NACK, CODE_BAD_KEY, 0, 0, 0);
                end else if (sh_mode != MODE_ERROR) begin
                    push_reply(KIND_NACK, CODE_NOT_ERR, 0, 0, 0);
                end else begin
                    log_head = 0;
                    log_fill = 0;
                    sh_mode = MODE_RECOVERY;
                    sh_clean = 0;
                    sh_rcv_start = c.now_ms;
                    push_reply(KIND_ACK, CODE_RST_ACK, 0, 0, 0);
                end
            end
            default: begin
                if (sh_mode != MODE_RECOVERY) begin
                    push_reply(KIND_STATUS, 8'h00, 0, 0, 0);
                end else if (c.now_ms - sh_rcv_start >= sh_timeout) begin
                    sh_mode = MODE_ERROR;
                    store_event(3'd0, SEV_CRIT, TIMEOUT_DET, c.now_ms);
                    push_reply(KIND_NACK, CODE_FAIL, 0, 0, 0);
                end else if (c.bus_mv >= sh_bus_ov) begin
                    sh_clean = 0;
                    store_event(3'd5, SEV_CRIT, c.bus_mv, c.now_ms);
                    push_reply(KIND_NACK, CODE_OVERVOLT, 0, 0, 0);
                end else begin
                    // first valid module at or over the limit fails the check
                    for (int i = 0; i < 3; i++) begin
                        if (!tripped && c.current_valid[i] && cur[i] >= sh_mod_oc) begin
                            tripped = 1;
                            sh_clean = 0;
                            store_event(3'(i + 1), SEV_CRIT, cur[i], c.now_ms);
                            push_reply(KIND_NACK, CODE_FAIL, 0, 0, 0);
                        end
                    end
                    if (!tripped) begin
                        sh_clean = sh_clean + 8'd1;
                        if (sh_clean >= sh_stable) begin
                            sh_mod_lock = '0;
                            sh_all_lock = 1'b0;
                            sh_clean = 0;
                            sh_mode = MODE_NORMAL;
                            push_reply(KIND_ACK, CODE_RCV_ACK, 0, 0, 0);
                        end else begin
                            push_reply(KIND_STATUS, 8'h00, 0, 0, 0);
                        end
                    end
                end
            end
        endcase
        expected_replies[expected_replies.size() - 1].last = 1'b1;
    endfunction

    // Driver: offers queued commands, predicting on each transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_replies(on_bus);
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    on_bus = pending_cmds.pop_front();
                    s_op                  <= on_bus.op;
                    s_now_ms              <= on_bus.now_ms;
                    s_source              <= on_bus.source;
                    s_severity            <= on_bus.severity;
                    s_detail              <= on_bus.detail;
                    s_key_present         <= on_bus.key_present;
                    s_reset_key           <= on_bus.reset_key;
                    s_bus_mv              <= on_bus.bus_mv;
                    s_drive_current_ma    <= on_bus.drive_ma;
                    s_extruder_current_ma <= on_bus.extruder_ma;
                    s_scrub_current_ma    <= on_bus.scrub_ma;
                    s_current_valid       <= on_bus.current_valid;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready, with an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            failed = 1;
        end
    endfunction

    // Monitor: compares each result transfer with the oldest expectation
    always @(posedge aclk) begin
        reply_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected result transfer, kind %0d", m_kind);
                failed = 1;
            end else begin
                e = expected_replies.pop_front();
                check_field("kind", e.kind, m_kind);
                check_field("reply_code", e.code, m_reply_code);
                check_field("entry_number", e.num, m_entry_number);
                check_field("entry_source", e.src, m_entry_source);
                check_field("entry_severity", e.sev, m_entry_severity);
                check_field("entry_detail", e.det, m_entry_detail);
                check_field("entry_time", e.stamp, m_entry_time);
                check_field("mode", e.mode, m_mode);
                check_field("power_allowed", e.power, m_power_allowed);
                check_field("lockout_mask", e.lock, m_lockout_mask);
                check_field("log_count", e.count, m_log_count);
                check_field("last", e.last, m_last);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_regs(logic [15:0] bus_ov, logic [15:0] mod_oc,
                              logic [31:0] tmo, logic [7:0] stable);
        logic [31:0] vals [4];
        logic [1:0]  idx  [4];
        vals = '{bus_ov, mod_oc, tmo, stable};
        idx  = '{REG_BUS_OV, REG_MOD_OC, REG_TIMEOUT, REG_STABLE};
        for (int i = 0; i < 4; i++) begin
            @(posedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
        sh_bus_ov  = bus_ov;
        sh_mod_oc  = mod_oc;
        sh_timeout = tmo;
        sh_stable  = stable;
    endtask

    function automatic command_t blank_cmd(op_t op);
        command_t c;
        c = '{op: OP_LOG, default: '0};
        c.op = op;
        clock_ms += $urandom_range(0, 40);
        c.now_ms = clock_ms;
        return c;
    endfunction

    function automatic command_t make_log(logic [2:0] src, logic [1:0] sev, logic [15:0] det);
        command_t c;
        c = blank_cmd(OP_LOG);
        c.source = src;
        c.severity = sev;
        c.detail = det;
        return c;
    endfunction

    function automatic command_t make_reset(logic kp, logic [7:0] key);
        command_t c;
        c = blank_cmd(OP_RESET);
        c.key_present = kp;
        c.reset_key = key;
        return c;
    endfunction

    // Recovery check; mostly below the limits so that clean runs occur
    function automatic command_t make_check();
        command_t c;
        c = blank_cmd(OP_CHECK);
        if ($urandom_range(0, 19) == 0) begin
            clock_ms += sh_timeout;
            c.now_ms = clock_ms;
        end
        c.bus_mv = 16'(($urandom_range(0, 9) < 8 && sh_bus_ov > 0) ?
                   $urandom_range(0, sh_bus_ov - 1) : $urandom_range(0, 65535));
        c.drive_ma    = 16'(($urandom_range(0, 9) < 9 && sh_mod_oc > 0) ?
                        $urandom_range(0, sh_mod_oc - 1) : $urandom_range(0, 65535));
        c.extruder_ma = 16'(($urandom_range(0, 9) < 9 && sh_mod_oc > 0) ?
                        $urandom_range(0, sh_mod_oc - 1) : $urandom_range(0, 65535));
        c.scrub_ma    = 16'(($urandom_range(0, 9) < 9 && sh_mod_oc > 0) ?
                        $urandom_range(0, sh_mod_oc - 1) : $urandom_range(0, 65535));
        c.current_valid = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd7;
        c.key_present = 1'($urandom_range(0, 1));
        c.reset_key = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Random commands: mostly fault, keyed reset and recovery sequences
    task automatic queue_random(int n);
        int made;
        int k;
        made = 0;
        while (made < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    pending_cmds.push_back(make_log(3'($urandom_range(0, 7)), SEV_CRIT,
                                                    16'($urandom_range(0, 65535))));
                    pending_cmds.push_back(make_reset(1'b1, RESET_KEY));
                    k = $urandom_range(1, 6);
                    repeat (k) pending_cmds.push_back(make_check());
                    made += k + 2;
                end
                4, 5: begin
                    pending_cmds.push_back(make_log(3'($urandom_range(0, 7)),
                                                    2'($urandom_range(0, 3)),
                                                    16'($urandom_range(0, 65535))));
                    made++;
                end
                6: begin
                    pending_cmds.push_back(blank_cmd(OP_DUMP));
                    made++;
                end
                7: begin
                    pending_cmds.push_back(make_reset(1'($urandom_range(0, 1)),
                                           $urandom_range(0, 3) == 0 ? RESET_KEY :
                                           8'($urandom_range(0, 255))));
                    made++;
                end
                default: begin
                    pending_cmds.push_back(make_check());
                    made++;
                end
            endcase
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_cmds.size() > 0 || s_valid || expected_replies.size() > 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic run_phase(int send_pct, int recv_pct, int n, logic [15:0] bus_ov,
                             logic [15:0] mod_oc, logic [31:0] tmo, logic [7:0] stable);
        write_regs(bus_ov, mod_oc, tmo, stable);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        queue_random(n);
        wait_idle();
    endtask

    initial begin
        command_t c;
        sh_bus_ov = 16'd30000;
        sh_mod_oc = 16'd10000;
        sh_timeout = 32'd5000;
        sh_stable = 8'd10;
        sh_mode = MODE_NORMAL;
        log_head = 0;
        log_fill = 0;
        sh_mod_lock = '0;
        sh_all_lock = 1'b0;
        sh_clean = '0;
        sh_rcv_start = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset-value registers, edge fields and each special case
        c = blank_cmd(OP_CHECK);
        c.bus_mv = 16'hFFFF;
        pending_cmds.push_back(c);                       // check outside recovery
        pending_cmds.push_back(make_log(3'd0, 2'd0, 16'h0000));
        pending_cmds.push_back(make_log(3'd7, 2'd3, 16'hFFFF)); // severity three
        pending_cmds.push_back(make_log(3'd6, SEV_WARN, 16'h5A5A));
        pending_cmds.push_back(make_reset(1'b0, RESET_KEY));
        pending_cmds.push_back(make_reset(1'b1, 8'h55));
        pending_cmds.push_back(make_reset(1'b1, RESET_KEY)); // not in error
        pending_cmds.push_back(blank_cmd(OP_DUMP));
        c = make_log(3'd2, SEV_CRIT, 16'h1234);
        c.now_ms = 32'hFFFF_FFF0;
        pending_cmds.push_back(c);
        c = make_reset(1'b1, RESET_KEY);
        c.now_ms = 32'hFFFF_FFF0;
        pending_cmds.push_back(c);
        c = blank_cmd(OP_CHECK);                         // invalid readings skipped
        c.now_ms = 32'h0000_0010;                        // elapsed wraps past zero
        c.drive_ma = 16'hFFFF;
        c.extruder_ma = 16'hFFFF;
        c.scrub_ma = 16'hFFFF;
        c.current_valid = 3'b000;
        pending_cmds.push_back(c);
        c.now_ms = 32'h0000_0020;
        c.current_valid = 3'b100;
        pending_cmds.push_back(c);                       // scrub overcurrent
        pending_cmds.push_back(make_reset(1'b1, RESET_KEY));
        c = blank_cmd(OP_CHECK);
        c.bus_mv = 16'd30000;
        pending_cmds.push_back(c);                       // bus overvoltage
        pending_cmds.push_back(make_reset(1'b1, RESET_KEY));
        c = blank_cmd(OP_CHECK);
        c.now_ms = c.now_ms + 32'd6000;
        pending_cmds.push_back(c);                       // timeout
        repeat (18) pending_cmds.push_back(make_log(3'($urandom_range(0, 7)), 2'd0,
                                                    16'($urandom_range(0, 65535))));
        pending_cmds.push_back(blank_cmd(OP_DUMP));      // wrapped full log
        wait_idle();

        run_phase(0, 0, 60, 16'd30000, 16'd10000, 32'd5000, 8'd3);
        clock_ms = 32'hFFFF_FF00;
        run_phase(68, 0, 50, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'd255);
        write_regs(16'd0, 16'd0, 32'd0, 8'd0);
        send_idle_pct = 0;
        recv_idle_pct = 68;
        hold_request = 1;
        queue_random(50);
        wait_idle();
        run_phase(12, 12, 60, 16'd20000, 16'd5000, 32'd200, 8'd1);

        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/fsel_pkg.sv
rtl/fsel_front.sv
rtl/fsel_back.sv
rtl/fault_supervisor_with_error_log.sv
rtl/fsel_checker.sv
verif/fault_supervisor_with_error_log_test.sv
